// ----- rtl/core/fwts_pkg.sv -----
// ============================================================================
// Fixed-weight ternary sampler package
// Shared constants, types and helper functions for the sampler, its
// remainder unit and its occupancy memory.
// ============================================================================
`default_nettype none

package fwts_pkg;

    // Largest supported vector length and the widths that follow from it.
    localparam int MAX_LENGTH  = 4096;
    localparam int IDX_W       = $clog2(MAX_LENGTH);
    localparam int LEN_W       = IDX_W + 1;
    localparam int WGT_W       = IDX_W;

    // Random input widths.
    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int BITS_W      = $clog2(BYTE_W) + 1;

    // Occupancy memory: one row holds ROW_BITS flags.
    localparam int ROW_BITS    = 32;
    localparam int BIT_AW      = $clog2(ROW_BITS);
    localparam int MAP_ROWS    = MAX_LENGTH / ROW_BITS;
    localparam int ROW_AW      = $clog2(MAP_ROWS);

    // Remainder unit: one dividend bit per step.
    localparam int DIV_STEPS   = WORD_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // Configuration port.
    localparam int CFG_DATA_W  = LEN_W;
    localparam int CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_WEIGHT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [LEN_W-1:0] LENGTH_RESET = LEN_W'(MAX_LENGTH);
    localparam logic [WGT_W-1:0] WEIGHT_RESET = WGT_W'(64);

    // Function codes of a request.
    localparam logic FUNC_DRAW    = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    // Ternary entry values in two-bit two's complement.
    localparam logic signed [1:0] VAL_ZERO = 2'sb00;
    localparam logic signed [1:0] VAL_POS  = 2'sb01;
    localparam logic signed [1:0] VAL_NEG  = 2'sb11;

    // Status of the remainder unit as seen by the sequencer.
    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] rem;
    } t_div_status;

    // Length register to the length actually used: zero acts as one and
    // anything above the maximum saturates.
    function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] n;
        n = len;
        if (n == '0) begin
            n = LEN_W'(1);
        end
        if (n > LEN_W'(MAX_LENGTH)) begin
            n = LEN_W'(MAX_LENGTH);
        end
        return n;
    endfunction

    // Weight register limited to half of the effective length.
    function automatic logic [WGT_W-1:0] eff_weight(input logic [WGT_W-1:0] wgt,
                                                    input logic [LEN_W-1:0] n);
        logic [WGT_W-1:0] half;
        half = n[LEN_W-1:1];
        return (wgt > half) ? half : wgt;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fixed_weight_ternary_sampler_unit.sv -----
// ============================================================================
// Fixed-weight ternary sampler
// Builds a ternary vector with a fixed number of nonzero entries from a
// stream of random draw requests.
// ============================================================================
// A request is taken when start is high and busy is low, and gives exactly
// one result, shown on the o_ ports for one cycle while o_valid is high; the
// receiver cannot stall it, so it must take every result as it comes. A draw
// request keeps busy high after acceptance while the bit-serial remainder
// unit reduces the random word by the vector length (32 steps, then the
// remainder is handed over), then while a 32-flag row of the occupancy
// memory is read and then updated. The result strobe comes in the first
// cycle with busy low, so a new draw is taken only once the last one is
// through. A restart request runs a clearing pass over the 128 rows of the
// occupancy memory, one row a cycle, keeps busy high through it and gives
// its result in the cycle after. The same clearing pass runs after reset,
// with busy high and no result. Configuration writes are taken at any time
// but should only be made while busy is low.
`default_nettype none

module fixed_weight_ternary_sampler_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Request channel
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                i_func,
    input  wire logic [fwts_pkg::WORD_W-1:0]         i_rand_word,
    input  wire logic [fwts_pkg::BYTE_W-1:0]         i_rand_byte,
    // Result channel
    output logic                                     o_valid,
    output logic                                     o_accepted,
    output logic [fwts_pkg::IDX_W-1:0]               o_entry_index,
    output logic signed [1:0]                        o_entry_value,
    output logic                                     o_byte_used,
    output logic                                     o_done_res,
    // Configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [fwts_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [fwts_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Sequencer states.
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;

    logic [2:0]                       r_state, n_state;
    logic [fwts_pkg::ROW_AW-1:0]      r_clr_row, n_clr_row;
    logic                             r_restart, n_restart;

    logic [fwts_pkg::LEN_W-1:0]       r_cfg_len;
    logic [fwts_pkg::WGT_W-1:0]       r_cfg_wgt;

    logic [fwts_pkg::LEN_W-1:0]       r_n, n_n;
    logic [fwts_pkg::WGT_W-1:0]       r_h, n_h;
    logic [fwts_pkg::BYTE_W-1:0]      r_byte, n_byte;
    logic [fwts_pkg::IDX_W-1:0]       r_idx, n_idx;

    logic [fwts_pkg::WGT_W-1:0]       r_placed, n_placed;
    logic [fwts_pkg::BYTE_W-1:0]      r_sign_buf, n_sign_buf;
    logic [fwts_pkg::BITS_W-1:0]      r_bits_left, n_bits_left;

    logic                             n_valid;
    logic                             n_accepted;
    logic [fwts_pkg::IDX_W-1:0]       n_entry_index;
    logic signed [1:0]                n_entry_value;
    logic                             n_byte_used;
    logic                             n_done_res;

    logic                             w_take;
    logic                             w_div_start;
    fwts_pkg::t_div_status            w_div;
    logic                             w_ram_we;
    logic [fwts_pkg::ROW_AW-1:0]      w_ram_waddr;
    logic [fwts_pkg::ROW_BITS-1:0]    w_ram_wdata;
    logic [fwts_pkg::ROW_BITS-1:0]    w_ram_rdata;
    logic [fwts_pkg::ROW_AW-1:0]      w_row;
    logic [fwts_pkg::BIT_AW-1:0]      w_bit;
    logic                             w_free;
    logic                             w_place;
    logic [fwts_pkg::BYTE_W-1:0]      w_buf;
    logic [fwts_pkg::LEN_W-1:0]       w_eff_n;

    assign busy   = (r_state != ST_IDLE);
    assign w_take = start && !busy;

    assign w_eff_n = fwts_pkg::eff_length(r_cfg_len);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len <= fwts_pkg::LENGTH_RESET;
            r_cfg_wgt <= fwts_pkg::WEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fwts_pkg::REG_VECTOR_LENGTH: r_cfg_len <= i_cfg_data;
                fwts_pkg::REG_TARGET_WEIGHT:
                    r_cfg_wgt <= i_cfg_data[fwts_pkg::WGT_W-1:0];
                default: ;
            endcase
        end
    end

    // Remainder unit: rand_word modulo the effective length.
    assign w_div_start = w_take && (i_func == fwts_pkg::FUNC_DRAW);

    fwts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_rand_word),
        .i_divisor  (w_eff_n),
        .o_status   (w_div)
    );

    // Occupancy memory addressing: upper index bits pick a row, the lower
    // bits pick a flag in it.
    assign w_row = r_idx[fwts_pkg::IDX_W-1:fwts_pkg::BIT_AW];
    assign w_bit = r_idx[fwts_pkg::BIT_AW-1:0];

    assign w_free  = !w_ram_rdata[w_bit];
    assign w_place = (r_state == ST_CHECK) && (r_placed < r_h) && w_free;

    assign w_ram_we    = (r_state == ST_CLEAR) || w_place;
    assign w_ram_waddr = (r_state == ST_CLEAR) ? r_clr_row : w_row;
    assign w_ram_wdata = (r_state == ST_CLEAR) ? '0
                         : (w_ram_rdata | (fwts_pkg::ROW_BITS'(1) << w_bit));

    fwts_ram #(
        .WIDTH (fwts_pkg::ROW_BITS),
        .DEPTH (fwts_pkg::MAP_ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_row),
        .o_rdata (w_ram_rdata)
    );

    // Sign buffer refills from the request's byte only when it is empty.
    assign w_buf = (r_bits_left == '0) ? r_byte : r_sign_buf;

    // Sequencer and per-request bookkeeping.
    always_comb begin
        n_state       = r_state;
        n_clr_row     = r_clr_row;
        n_restart     = r_restart;
        n_n           = r_n;
        n_h           = r_h;
        n_byte        = r_byte;
        n_idx         = r_idx;
        n_placed      = r_placed;
        n_sign_buf    = r_sign_buf;
        n_bits_left   = r_bits_left;
        n_valid       = 1'b0;
        n_accepted    = 1'b0;
        n_entry_index = '0;
        n_entry_value = fwts_pkg::VAL_ZERO;
        n_byte_used   = 1'b0;
        n_done_res    = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                n_clr_row = r_clr_row + 1'b1;
                if (r_clr_row == fwts_pkg::ROW_AW'(fwts_pkg::MAP_ROWS - 1)) begin
                    n_state   = ST_IDLE;
                    n_restart = 1'b0;
                    if (r_restart) begin
                        n_valid    = 1'b1;
                        n_done_res = (r_h == '0);
                    end
                end
            end
            ST_IDLE: begin
                if (w_take) begin
                    n_n    = w_eff_n;
                    n_h    = fwts_pkg::eff_weight(r_cfg_wgt, w_eff_n);
                    n_byte = i_rand_byte;
                    if (i_func == fwts_pkg::FUNC_RESTART) begin
                        n_state     = ST_CLEAR;
                        n_clr_row   = '0;
                        n_restart   = 1'b1;
                        n_placed    = '0;
                        n_sign_buf  = '0;
                        n_bits_left = '0;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (w_div.done) begin
                    n_idx   = w_div.rem;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state       = ST_IDLE;
                n_valid       = 1'b1;
                n_entry_index = r_idx;
                if (w_place) begin
                    n_placed      = r_placed + 1'b1;
                    n_accepted    = 1'b1;
                    n_byte_used   = (r_bits_left == '0);
                    n_entry_value = w_buf[0] ? fwts_pkg::VAL_POS : fwts_pkg::VAL_NEG;
                    n_sign_buf    = w_buf >> 1;
                    n_bits_left   = ((r_bits_left == '0)
                                     ? fwts_pkg::BITS_W'(fwts_pkg::BYTE_W)
                                     : r_bits_left) - 1'b1;
                end
                n_done_res = (n_placed >= r_h);
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and vector state registers; reset starts a clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_row   <= '0;
            r_restart   <= 1'b0;
            r_placed    <= '0;
            r_sign_buf  <= '0;
            r_bits_left <= '0;
            r_h         <= '0;
            r_n         <= fwts_pkg::LENGTH_RESET;
            o_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_row   <= n_clr_row;
            r_restart   <= n_restart;
            r_placed    <= n_placed;
            r_sign_buf  <= n_sign_buf;
            r_bits_left <= n_bits_left;
            r_h         <= n_h;
            r_n         <= n_n;
            o_valid     <= n_valid;
        end
        r_byte        <= n_byte;
        r_idx         <= n_idx;
        o_accepted    <= n_accepted;
        o_entry_index <= n_entry_index;
        o_entry_value <= n_entry_value;
        o_byte_used   <= n_byte_used;
        o_done_res    <= n_done_res;
    end

    // A placed entry is always nonzero; a rejected one is zero and uses no byte.
    a_value_matches_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_accepted ? (o_entry_value != fwts_pkg::VAL_ZERO)
                                : (o_entry_value == fwts_pkg::VAL_ZERO && !o_byte_used)))
        else $error("entry value does not match the accept flag");

    // The reported index lies inside the effective length.
    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_entry_index} < r_n))
        else $error("entry index outside the vector length");

    // The sign buffer never claims more bits than one byte holds.
    a_bits_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits_left <= fwts_pkg::BITS_W'(fwts_pkg::BYTE_W))
        else $error("sign buffer bit count overflow");

    // The placed count never passes the weight of the current vector.
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_accepted) |-> (r_placed <= r_h))
        else $error("placed count above target weight");

    // The map is written only by the clearing pass or by a placing draw.
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == ST_CLEAR || r_state == ST_CHECK))
        else $error("occupancy memory written outside clear or check");

    // An accepted request makes the block busy in the next cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> busy)
        else $error("block not busy after taking a request");

endmodule

`default_nettype wire

// ----- rtl/core/fwts_ram.sv -----
// ============================================================================
// Generic single-clock RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module fwts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/fwts_div.sv -----
// ============================================================================
// Sampler remainder unit
// Restoring remainder of a 32-bit word by the vector length, one dividend
// bit per clock cycle.
// ============================================================================
`default_nettype none

module fwts_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [fwts_pkg::WORD_W-1:0]    i_dividend,
    input  wire logic [fwts_pkg::LEN_W-1:0]     i_divisor,
    output fwts_pkg::t_div_status               o_status
);

    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic [fwts_pkg::DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic [fwts_pkg::WORD_W-1:0]     r_word, n_word;
    logic [fwts_pkg::IDX_W-1:0]      r_rem, n_rem;
    logic [fwts_pkg::LEN_W-1:0]      r_dsr, n_dsr;
    logic [fwts_pkg::LEN_W-1:0]      w_shift;
    logic [fwts_pkg::LEN_W-1:0]      w_diff;

    // One restoring step: bring in the next dividend bit and subtract the
    // divisor when it fits. The partial remainder stays below the divisor.
    assign w_shift = {r_rem, r_word[fwts_pkg::WORD_W-1]};
    assign w_diff  = w_shift - r_dsr;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_word = r_word;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_word = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_word = {r_word[fwts_pkg::WORD_W-2:0], 1'b0};
            n_rem  = (w_shift >= r_dsr) ? w_diff[fwts_pkg::IDX_W-1:0]
                                        : w_shift[fwts_pkg::IDX_W-1:0];
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == fwts_pkg::DIV_CNT_W'(fwts_pkg::DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state is reset; the data path is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_word <= n_word;
        r_rem  <= n_rem;
        r_dsr  <= n_dsr;
    end

    assign o_status.done = r_done;
    assign o_status.rem  = r_rem;

endmodule

`default_nettype wire
